@@ rtl/scs_pkg.sv @@
// Shared types and constants for the slewed channel subtractor.
`timescale 1ns / 1ps
package scs_pkg;

    localparam int DEFAULT_MAX_CHANNELS = 8;
    localparam int DEFAULT_SAMPLE_BITS  = 24;

    localparam int CH_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_B_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING   = 2'd2;

    typedef struct packed {
        logic                b_mode;
        logic                slew_enable;
        logic [ALPHA_W-1:0]  alpha;
    } cfg_t;

    // Classification of one queued transaction
    typedef struct packed {
        logic update;      // smoother advances on this transaction
        logic use_shared;  // shared smoother instead of the channel slot
    } ctrl_t;

    localparam int CTRL_W = $bits(ctrl_t);

endpackage

@@ rtl/scs_ifs.sv @@
// Channel interfaces: sample input, result output and configuration write.
`timescale 1ns / 1ps
interface scs_in_if import scs_pkg::*; #(
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] a_sample;
    logic signed [SAMPLE_BITS-1:0] b_sample;

    modport source (output valid, output channel, output a_sample, output b_sample,
                    input ready);
    modport sink   (input valid, input channel, input a_sample, input b_sample,
                    output ready);
endinterface

interface scs_out_if import scs_pkg::*; #(
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic [CH_W-1:0]               channel_out;
    logic signed [SAMPLE_BITS-1:0] difference;

    modport source (output valid, output channel_out, output difference, input ready);
    modport sink   (input valid, input channel_out, input difference, output ready);
endinterface

interface scs_cfg_if import scs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ALPHA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/scs_cfg_regs.sv @@
// Configuration register file.
`timescale 1ns / 1ps
module scs_cfg_regs import scs_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    scs_cfg_if.sink  cfg,
    output cfg_t     cfg_q
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_B_MODE:      cfg_next.b_mode      = cfg.data[0];
                CFG_SLEW_ENABLE: cfg_next.slew_enable = cfg.data[0];
                CFG_SMOOTHING:   cfg_next.alpha       = cfg.data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.b_mode      <= 1'b0;
            cfg_reg.slew_enable <= 1'b0;
            cfg_reg.alpha       <= ALPHA_ONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/scs_front.sv @@
// Front end: accepts samples, picks the smoother and state slot, queues them.
`timescale 1ns / 1ps
module scs_front import scs_pkg::*; #(
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
    parameter int STATE_DEPTH = DEFAULT_MAX_CHANNELS,
    parameter int SLOT_W      = 3,
    parameter int QW          = CH_W + CTRL_W + SLOT_W + 2 * SAMPLE_BITS
) (
    scs_in_if.sink            samples,
    input  logic              b_mode,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [QW-1:0]     push_data
);

    localparam logic [CH_W:0] DEPTH_V = (CH_W + 1)'(STATE_DEPTH);

    // Channel modulo the slot count by repeated subtraction on a 4-bit copy of the 3-bit channel
    function automatic logic [SLOT_W-1:0] slot_of(input logic [CH_W-1:0] ch);
        logic [CH_W:0] v;
        v = {1'b0, ch};
        for (int i = 0; i < (1 << CH_W); i++)
        begin
            if (v >= DEPTH_V)
                v = v - DEPTH_V;
        end
        return v[SLOT_W-1:0];
    endfunction

    ctrl_t ctrl;

    always_comb
    begin
        if (b_mode)
        begin
            ctrl.update     = (samples.channel == '0);
            ctrl.use_shared = 1'b1;
        end
        else
        begin
            ctrl.update     = 1'b1;
            ctrl.use_shared = 1'b0;
        end
    end

    assign samples.ready = push_ready;
    assign push_valid    = samples.valid;
    assign push_data     = {samples.channel, ctrl, slot_of(samples.channel),
                            samples.a_sample, samples.b_sample};

endmodule

@@ rtl/scs_queue.sv @@
// Short FIFO between the front end and the smoother back end.
`timescale 1ns / 1ps
module scs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ rtl/scs_back.sv @@
// Back end: one-pole smoother update, then saturated subtraction and output register.
`timescale 1ns / 1ps
module scs_back import scs_pkg::*; #(
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
    parameter int STATE_DEPTH = DEFAULT_MAX_CHANNELS,
    parameter int SLOT_W      = 3,
    parameter int QW          = CH_W + CTRL_W + SLOT_W + 2 * SAMPLE_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg_q,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  logic [QW-1:0]  pop_data,
    scs_out_if.source      results
);

    localparam int S    = SAMPLE_BITS;
    localparam int PW   = S + 1 + ALPHA_W + 1;
    localparam logic signed [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
    localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (ALPHA_FRAC - 1);

    logic [CH_W-1:0]         q_ch;
    ctrl_t                   q_ctrl;
    logic [SLOT_W-1:0]       q_slot;
    logic signed [S-1:0]     q_a, q_b;

    assign {q_ch, q_ctrl, q_slot, q_a, q_b} = pop_data;

    // Smoother state
    logic signed [S-1:0]     chan_state_reg [STATE_DEPTH];
    logic [STATE_DEPTH-1:0]  chan_primed_reg;
    logic signed [S-1:0]     shared_state_reg;
    logic                    shared_primed_reg;

    // Pipeline registers
    logic                    mid_valid_reg;
    logic [CH_W-1:0]         mid_ch_reg;
    logic signed [S-1:0]     mid_a_reg, mid_sb_reg;
    logic                    out_valid_reg;
    logic [CH_W-1:0]         out_ch_reg;
    logic signed [S-1:0]     out_diff_reg;

    logic                    out_adv, pop;
    logic signed [S-1:0]     state;
    logic                    primed;
    logic [ALPHA_W-1:0]      alpha;
    logic signed [S:0]       delta;
    logic signed [PW-1:0]    prod, rounded, step;
    logic signed [S:0]       sum;
    logic signed [S-1:0]     state_next, sb;
    logic signed [S:0]       diff_wide;
    logic signed [S-1:0]     diff_sat;

    assign out_adv   = !out_valid_reg || results.ready;
    assign pop_ready = !mid_valid_reg || out_adv;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        state  = q_ctrl.use_shared ? shared_state_reg  : chan_state_reg[q_slot];
        primed = q_ctrl.use_shared ? shared_primed_reg : chan_primed_reg[q_slot];
        alpha  = (cfg_q.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_q.alpha;
        delta  = (S + 1)'(q_b) - (S + 1)'(state);
        prod   = PW'(delta) * $signed(PW'({1'b0, alpha}));
        // Arithmetic shift floors, which with the half added rounds half up
        rounded = prod + ROUND_HALF;
        step    = rounded >>> ALPHA_FRAC;
        sum     = (S + 1)'(state) + step[S:0];
        if (!primed || !cfg_q.slew_enable)
            state_next = q_b;
        else
            state_next = sum[S-1:0];
        if (q_ctrl.update)
            sb = state_next;
        else
            sb = primed ? state : q_b;
    end

    always_comb
    begin
        diff_wide = (S + 1)'(mid_a_reg) - (S + 1)'(mid_sb_reg);
        if (diff_wide[S] != diff_wide[S-1])
            diff_sat = diff_wide[S] ? SMIN : SMAX;
        else
            diff_sat = diff_wide[S-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_ctrl.update)
        begin
            if (q_ctrl.use_shared)
                shared_state_reg <= state_next;
            else
                chan_state_reg[q_slot] <= state_next;
        end
        if (pop)
        begin
            mid_ch_reg <= q_ch;
            mid_a_reg  <= q_a;
            mid_sb_reg <= sb;
        end
        if (out_adv && mid_valid_reg)
        begin
            out_ch_reg   <= mid_ch_reg;
            out_diff_reg <= diff_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_primed_reg   <= '0;
            shared_primed_reg <= 1'b0;
            mid_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop && q_ctrl.update)
            begin
                if (q_ctrl.use_shared)
                    shared_primed_reg <= 1'b1;
                else
                    chan_primed_reg[q_slot] <= 1'b1;
            end
            if (pop)
                mid_valid_reg <= 1'b1;
            else if (out_adv)
                mid_valid_reg <= 1'b0;
            if (out_adv)
                out_valid_reg <= mid_valid_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.channel_out = out_ch_reg;
    assign results.difference  = out_diff_reg;

endmodule

@@ rtl/slewed_channel_subtractor_unit.sv @@
// Path from sample transaction to result valid: queue, smoother stage, then subtract
// stage; the queue has no bypass, so even an empty queue is a registered stage.
// Throughput: one sample per cycle while results are taken; the smoother read-modify-write
// of a state slot completes at its pop, so consecutive same-channel samples do not stall.
// Reset: all smoothers unprimed, b_mode 0, slew disabled, alpha 1.0; queue and output
// pipeline empty. No clearing pass: primed bits reset at once.
`timescale 1ns / 1ps
module slewed_channel_subtractor_unit import scs_pkg::*; #(
    parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = DEFAULT_SAMPLE_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    scs_in_if.sink     samples,
    scs_out_if.source  results,
    scs_cfg_if.sink    cfg
);

    // Channel numbers are 3 bits, so no more than eight slots are ever reached
    localparam int STATE_DEPTH = (MAX_CHANNELS < (1 << CH_W)) ? MAX_CHANNELS : (1 << CH_W);
    localparam int SLOT_W      = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
    localparam int QW          = CH_W + CTRL_W + SLOT_W + 2 * SAMPLE_BITS;
    localparam int QUEUE_DEPTH = 2;

    cfg_t            cfg_q;
    logic            push_valid, push_ready;
    logic [QW-1:0]   push_data;
    logic            pop_valid, pop_ready;
    logic [QW-1:0]   pop_data;

    scs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    scs_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_DEPTH (STATE_DEPTH),
        .SLOT_W      (SLOT_W),
        .QW          (QW)
    ) u_front (
        .samples    (samples),
        .b_mode     (cfg_q.b_mode),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    scs_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    scs_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_DEPTH (STATE_DEPTH),
        .SLOT_W      (SLOT_W),
        .QW          (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_q     (cfg_q),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .results   (results)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the slewed channel subtractor unit.
`timescale 1ns / 1ps

import scs_pkg::*;

typedef logic signed [DEFAULT_SAMPLE_BITS-1:0] sample_t;
typedef logic [CH_W-1:0] chan_t;

localparam sample_t SAMPLE_MAX = {1'b0, {(DEFAULT_SAMPLE_BITS-1){1'b1}}};
localparam sample_t SAMPLE_MIN = {1'b1, {(DEFAULT_SAMPLE_BITS-1){1'b0}}};
localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

class slew_diff_scoreboard;
    typedef struct {
        chan_t   channel;
        sample_t difference;
    } diff_result_t;

    diff_result_t       expected_diffs[$];
    bit                 shared_mode;
    bit                 slew_on;
    logic [ALPHA_W-1:0] alpha;
    sample_t            chan_smoothed[DEFAULT_MAX_CHANNELS];
    bit                 chan_primed[DEFAULT_MAX_CHANNELS];
    sample_t            shared_smoothed;
    bit                 shared_primed;
    int                 mismatches;

    function new();
        shared_mode = 1'b0;
        slew_on = 1'b0;
        alpha = ALPHA_ONE;
        for (int i = 0; i < DEFAULT_MAX_CHANNELS; i++)
        begin
            chan_smoothed[i] = '0;
            chan_primed[i] = 1'b0;
        end
        shared_smoothed = '0;
        shared_primed = 1'b0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [ALPHA_W-1:0] data);
        case (index)
            CFG_B_MODE:      shared_mode = data[0];
            CFG_SLEW_ENABLE: slew_on = data[0];
            CFG_SMOOTHING:   alpha = data;
            default:         ;
        endcase
    endfunction

    // One-pole step with round half up; alpha above one clamps to one
    function sample_t smooth_step(sample_t state, bit primed, sample_t target);
        longint coef;
        longint step;
        if (!primed || !slew_on)
            return target;
        coef = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
        step = (coef * (longint'(target) - longint'(state)) + 32768) >>> ALPHA_FRAC;
        return sample_t'(longint'(state) + step);
    endfunction

    function void note_sample(chan_t ch, sample_t a, sample_t b);
        int           slot;
        sample_t      smoothed_b;
        longint       diff;
        diff_result_t res;
        slot = int'(ch) % DEFAULT_MAX_CHANNELS;
        if (shared_mode)
        begin
            if (ch == 0)
            begin
                shared_smoothed = smooth_step(shared_smoothed, shared_primed, b);
                shared_primed = 1'b1;
                smoothed_b = shared_smoothed;
            end
            else
                smoothed_b = shared_primed ? shared_smoothed : b;
        end
        else
        begin
            chan_smoothed[slot] = smooth_step(chan_smoothed[slot], chan_primed[slot], b);
            chan_primed[slot] = 1'b1;
            smoothed_b = chan_smoothed[slot];
        end
        diff = longint'(a) - longint'(smoothed_b);
        if (diff > longint'(SAMPLE_MAX))
            diff = longint'(SAMPLE_MAX);
        if (diff < longint'(SAMPLE_MIN))
            diff = longint'(SAMPLE_MIN);
        res.channel = ch;
        res.difference = sample_t'(diff);
        expected_diffs.push_back(res);
    endfunction

    function void check_result(chan_t ch, sample_t diff);
        diff_result_t want;
        if (expected_diffs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with nothing pending: channel %0d difference %0d",
                         ch, diff);
            return;
        end
        want = expected_diffs.pop_front();
        if (ch !== want.channel || diff !== want.difference)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: expected channel %0d difference %0d, got channel %0d difference %0d",
                         want.channel, want.difference, ch, diff);
        end
    endfunction

    function int pending();
        return expected_diffs.size();
    endfunction
endclass

module tb_top;
    localparam int LATENCY      = 3;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 200;

    logic clk = 1'b0;
    logic rst_n;

    scs_in_if  samples_if ();
    scs_out_if results_if ();
    scs_cfg_if cfg_if ();

    slewed_channel_subtractor_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    slew_diff_scoreboard diff_board = new();

    int      cycles = 0;
    bit      send_quiet = 1'b0;
    int      send_stretch = 0;
    bit      recv_quiet = 1'b0;
    int      recv_stretch = 0;
    int      stall_left = 0;
    sample_t last_b[DEFAULT_MAX_CHANNELS];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, with quiet stretches of no gaps at all
    function automatic int pick_gap(inout bit quiet, inout int stretch);
        int r;
        if (stretch == 0)
        begin
            stretch = $urandom_range(30, 300);
            quiet = ($urandom_range(0, 3) == 0);
        end
        stretch--;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t rand_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return sample_t'($signed($urandom_range(0, 600)) - 300);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Favor steady or slowly moving targets so the smoother settles
    function automatic sample_t rand_target(chan_t ch);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return last_b[ch];
        if (r < 5)
            return sample_t'(last_b[ch] + $signed($urandom_range(0, 64)) - 32);
        return rand_sample();
    endfunction

    task automatic send_sample(chan_t ch, sample_t a, sample_t b);
        int gap;
        gap = pick_gap(send_quiet, send_stretch);
        @(negedge clk);
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_if.channel  <= ch;
        samples_if.a_sample <= a;
        samples_if.b_sample <= b;
        samples_if.valid    <= 1'b1;
        do
            @(posedge clk);
        while (!samples_if.ready);
        diff_board.note_sample(ch, a, b);
        last_b[ch] = b;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [ALPHA_W-1:0] data);
        @(negedge clk);
        cfg_if.index <= index;
        cfg_if.data  <= data;
        cfg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        diff_board.write_reg(index, data);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Drop valid and wait until the pipeline has drained
    task automatic settle();
        @(negedge clk);
        samples_if.valid <= 1'b0;
        while (diff_board.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic logic [ALPHA_W-1:0] pick_alpha(int phase);
        int r;
        case (phase)
            0: return ALPHA_ONE;
            1: return '0;
            2: return {ALPHA_W{1'b1}};
            3: return ALPHA_W'(1);
            4: return ALPHA_W'(65535);
            default:
            begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    return ALPHA_W'($urandom_range(1, 2000));
                if (r == 1)
                    return ALPHA_W'($urandom_range(65537, 131071));
                return ALPHA_W'($urandom);
            end
        endcase
    endfunction

    task automatic run_directed();
        // reset setting: no slew, per-channel, saturation both ways
        send_sample(3'd0, SAMPLE_MAX, SAMPLE_MIN);
        send_sample(3'd7, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(3'd3, '0, '0);
        send_sample(3'd5, -24'sd1, 24'sd1);
        settle();
        write_reg(CFG_SLEW_ENABLE, 17'h1_0001);
        write_reg(CFG_SMOOTHING, ALPHA_W'(32768));
        send_sample(3'd0, '0, SAMPLE_MAX);
        send_sample(3'd0, '0, SAMPLE_MAX);
        send_sample(3'd1, 24'sd100, -24'sd100);
        send_sample(3'd7, SAMPLE_MAX, SAMPLE_MIN);
        settle();
        write_reg(CFG_SMOOTHING, {ALPHA_W{1'b1}});
        send_sample(3'd0, '0, 24'sd12345);
        settle();
        write_reg(CFG_SMOOTHING, '0);
        send_sample(3'd0, '0, SAMPLE_MIN);
        settle();
        // tiny alpha: steps round to at most one, far short of the target
        write_reg(CFG_SMOOTHING, ALPHA_W'(1));
        send_sample(3'd3, '0, 24'sd40000);
        send_sample(3'd3, '0, 24'sd40000);
        send_sample(3'd4, '0, 24'sd1);
        send_sample(3'd3, '0, 24'sd1);
        settle();
        write_reg(CFG_SPARE, 17'h1_5A5A);
        write_reg(CFG_B_MODE, 17'h1_FFFF);
        // shared smoother still unprimed: other channels use their own target
        send_sample(3'd5, 24'sd10, 24'sd20);
        send_sample(3'd2, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(3'd0, '0, 24'sd500);
        send_sample(3'd6, '0, -24'sd7);
        send_sample(3'd0, '0, SAMPLE_MAX);
        settle();
        write_reg(CFG_B_MODE, 17'h0_0000);
        send_sample(3'd0, 24'sd1, '0);
        settle();
        write_reg(CFG_SLEW_ENABLE, 17'h0_FFFE);
        send_sample(3'd2, 24'sd3, 24'sd4);
    endtask

    task automatic run_random();
        int   sent;
        int   frame_len;
        chan_t ch;
        bit   shared;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            shared = (phase % 2 == 1) ^ ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, ALPHA_W'($urandom));
            write_reg(CFG_B_MODE, {ALPHA_W'($urandom) & ~ALPHA_W'(1)} | ALPHA_W'(shared));
            write_reg(CFG_SLEW_ENABLE,
                      (ALPHA_W'($urandom) & ~ALPHA_W'(1)) | ALPHA_W'($urandom_range(0, 4) != 0));
            write_reg(CFG_SMOOTHING, pick_alpha(phase));
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (shared && $urandom_range(0, 99) < 85)
                begin
                    // well-formed frame: channel 0 first, then the rest in order
                    frame_len = $urandom_range(1, DEFAULT_MAX_CHANNELS);
                    for (int c = 0; c < frame_len; c++)
                    begin
                        ch = chan_t'(c);
                        send_sample(ch, rand_sample(), rand_target(ch));
                    end
                    sent += frame_len;
                end
                else
                begin
                    ch = chan_t'($urandom_range(0, DEFAULT_MAX_CHANNELS - 1));
                    send_sample(ch, rand_sample(), rand_target(ch));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        samples_if.valid    = 1'b0;
        samples_if.channel  = '0;
        samples_if.a_sample = '0;
        samples_if.b_sample = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        for (int i = 0; i < DEFAULT_MAX_CHANNELS; i++)
            last_b[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        run_random();
        settle();
        if (diff_board.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: random backpressure
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                results_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap(recv_quiet, recv_stretch);
                if (stall_left > 0)
                begin
                    results_if.ready <= 1'b0;
                    stall_left--;
                end
                else
                    results_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            diff_board.check_result(results_if.channel_out, results_if.difference);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end
endmodule

@@ filelist.f @@
rtl/scs_pkg.sv
rtl/scs_ifs.sv
rtl/scs_cfg_regs.sv
rtl/scs_front.sv
rtl/scs_queue.sv
rtl/scs_back.sv
rtl/slewed_channel_subtractor_unit.sv
sim/tb_top.sv
